[src/ir_manchester_frame_transmitter_core_assert.svh]
// Assertion macros for the IR Manchester frame transmitter modules.
// Expect signals named clk and rst_n in the module that uses them.
`ifndef IR_MANCHESTER_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define IR_MANCHESTER_FRAME_TRANSMITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define IRMFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ir_mft assertion failed");
// Check that a condition in one cycle implies another in the next.
`define IRMFT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ir_mft assertion failed");
`else
`define IRMFT_ASSERT(lbl, prop)
`define IRMFT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[src/ir_mft_pkg.sv]
// Shared types and constants for the IR Manchester frame transmitter.
// No dependencies.
package ir_mft_pkg;

  // Input item kinds carried on in_tuser
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  // Frame header: three fixed ones ahead of the command bits
  localparam int       HEADER_BITS = 3;
  localparam logic [2:0] HEADER_ONES = 3'b111;

  // Reset value of the half-bit period register, in ticks
  localparam logic [15:0] HALF_BIT_RESET = 16'd889;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage

[src/ir_mft_engine.sv]
// Frame state and per-transaction next-state logic of the IR transmitter.
// Depends on ir_mft_pkg and the assertion macro header.
`include "ir_manchester_frame_transmitter_core_assert.svh"

module ir_mft_engine #(
  parameter int DATA_BITS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata,
  input  logic               item_acc,
  input  logic               item_action,
  input  logic [15:0]        item_data,
  output ir_mft_pkg::result_t res
);

  localparam int FRAME_BITS = ir_mft_pkg::HEADER_BITS + DATA_BITS;
  localparam int POS_W      = $clog2(FRAME_BITS + 1);
  localparam logic [15:0] DATA_MASK =
    (DATA_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DATA_BITS) - 32'd1);
  localparam logic [FRAME_BITS-1:0] HDR_FRAME =
    FRAME_BITS'(ir_mft_pkg::HEADER_ONES) << DATA_BITS;
  localparam logic [POS_W-1:0] POS_END = POS_W'(FRAME_BITS);

  logic [15:0]           half_r;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  second_r, second_nxt;
  logic [15:0]           tick_r, tick_nxt;
  logic                  carrier_r, carrier_nxt;
  logic                  sending_r, sending_nxt;
  logic [15:0]           tick_inc;
  logic                  done;
  logic                  rej;

  assign tick_inc = tick_r + 16'd1;

  always_comb begin
    frame_nxt   = frame_r;
    pos_nxt     = pos_r;
    second_nxt  = second_r;
    tick_nxt    = tick_r;
    carrier_nxt = carrier_r;
    sending_nxt = sending_r;
    done        = 1'b0;
    rej         = 1'b0;
    if (item_acc) begin
      if (item_action == ir_mft_pkg::ACT_SEND) begin
        if (|(item_data & ~DATA_MASK)) begin
          rej = 1'b1;
        end else begin
          frame_nxt   = HDR_FRAME | FRAME_BITS'(item_data & DATA_MASK);
          pos_nxt     = '0;
          second_nxt  = 1'b0;
          tick_nxt    = '0;
          carrier_nxt = 1'b0;
          sending_nxt = 1'b1;
        end
      end else if (sending_r) begin
        tick_nxt = tick_inc;
        if (tick_inc >= half_r) begin
          tick_nxt = '0;
          priority if (pos_r >= POS_END) begin
            carrier_nxt = 1'b0;
            sending_nxt = 1'b0;
            pos_nxt     = '0;
            second_nxt  = 1'b0;
            done        = 1'b1;
          end else if (!second_r) begin
            carrier_nxt = frame_r[FRAME_BITS-1];
            second_nxt  = 1'b1;
          end else begin
            // second half: inverted level, then advance to the next bit
            carrier_nxt = ~frame_r[FRAME_BITS-1];
            second_nxt  = 1'b0;
            pos_nxt     = pos_r + POS_W'(1);
            frame_nxt   = frame_r << 1;
          end
        end
      end
    end
  end

  always_comb begin
    res.carrier_on = carrier_nxt;
    res.busy_res   = sending_nxt;
    res.frame_done = done;
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= ir_mft_pkg::HALF_BIT_RESET;
      frame_r   <= '0;
      pos_r     <= '0;
      second_r  <= 1'b0;
      tick_r    <= '0;
      carrier_r <= 1'b0;
      sending_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        half_r <= cfg_wdata;
      end
      frame_r   <= frame_nxt;
      pos_r     <= pos_nxt;
      second_r  <= second_nxt;
      tick_r    <= tick_nxt;
      carrier_r <= carrier_nxt;
      sending_r <= sending_nxt;
    end
  end

  `IRMFT_ASSERT(a_pos_in_range, pos_r <= POS_END)
  `IRMFT_ASSERT(a_idle_count_clear, !sending_r |-> (tick_r == 16'd0))
  `IRMFT_ASSERT(a_idle_carrier_off, !sending_r |-> !carrier_r)

endmodule

[src/ir_mft_out_buf.sv]
// Result register with a skid stage for the IR transmitter result channel.
// Depends on ir_mft_pkg and the assertion macro header.
`include "ir_manchester_frame_transmitter_core_assert.svh"

module ir_mft_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ir_mft_pkg::result_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output ir_mft_pkg::result_t out_data
);

  logic                main_vld_r;
  ir_mft_pkg::result_t main_r;
  logic                skid_vld_r;
  ir_mft_pkg::result_t skid_r;
  logic                pop;

  assign pop       = main_vld_r && out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // no push is possible while the skid holds a result
      if (pop) begin
        main_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r     <= push_data;
        main_vld_r <= 1'b1;
      end else begin
        skid_r     <= push_data;
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  `IRMFT_ASSERT(a_skid_behind_main, skid_vld_r |-> main_vld_r)
  `IRMFT_ASSERT_NEXT(a_skid_holds, skid_vld_r && !pop, skid_vld_r && main_vld_r)
  `IRMFT_ASSERT_NEXT(a_stall_fills_skid, push && main_vld_r && !out_ready, skid_vld_r)

endmodule

[src/ir_manchester_frame_transmitter_core.sv]
// Top level of the RC5-style IR Manchester frame transmitter.
// Depends on ir_mft_pkg, ir_mft_engine and ir_mft_out_buf.
//
// Usage:
//   Input channel (in_*): in_tuser selects the kind of transaction, 0 for a
//   one-microsecond tick and 1 for a send; in_tdata carries the command word.
//   A send with any bit at or above DATA_BITS set is rejected and changes
//   nothing. An accepted send restarts the frame: three header ones, then
//   the command MSB first, each bit as two half-bit periods (1 = carrier on
//   then off, 0 = off then on).
//   Result channel (out_*): one transaction per input transaction, in order,
//   holding the carrier enable and busy flag after that item, the reject
//   flag, and out_tlast on the tick that ends a frame.
//   Configuration: cfg_wen writes cfg_wdata into the half-bit period (ticks)
//   at once; write only while the block is idle. Reset value is 889.
// Throughput: one transaction per cycle while in_tready is high; each result
//   is registered in the result register, or in the skid stage during a stall,
//   before it appears on out_*. The rate is set by the engine's frame state update.
// Stalls: a result register plus a skid stage take one more item while the
//   receiver holds out_tready low; in_tready then drops until it drains.
// Reset: synchronous, active low; idle, carrier off, no results pending.
module ir_manchester_frame_transmitter_core #(
  parameter int DATA_BITS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,   // half_bit_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] data
  input  logic        in_tuser,    // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] carrier_on, [1] busy_res, [2] rejected, [7:3] zero
  output logic        out_tlast    // frame_done
);

  logic                item_acc;
  ir_mft_pkg::result_t res;
  ir_mft_pkg::result_t out_res;

  // Advance the frame state only on an accepted transaction
  assign item_acc = in_tvalid && in_tready;

  ir_mft_engine #(
    .DATA_BITS (DATA_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .item_acc    (item_acc),
    .item_action (in_tuser),
    .item_data   (in_tdata),
    .res         (res)
  );

  // Hold results here so the input side keeps moving during short stalls
  ir_mft_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_data (res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {5'b00000, out_res.rejected, out_res.busy_res, out_res.carrier_on};
  assign out_tlast = out_res.frame_done;

endmodule

[tb/sv/ir_manchester_frame_transmitter_core_tb.sv]
// Self-checking testbench for ir_manchester_frame_transmitter_core.
// Drives ticks and sends on the input stream and scores every result against a
// built-in frame predictor. Depends on ir_mft_pkg and the core RTL only.
module ir_manchester_frame_transmitter_core_tb;

  localparam int DATA_BITS   = 11;
  localparam int FRAME_BITS  = ir_mft_pkg::HEADER_BITS + DATA_BITS;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 145;

  // Half-bit period per random phase: extremes, the zero-acts-as-one case, small values
  localparam logic [15:0] HALF_SETTINGS [PHASES] = '{
    16'd1, 16'd2, 16'd65535, 16'd0, 16'd3, 16'd889, 16'd1, 16'd5, 16'd2
  };

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One directed stimulus row; for ROW_CFG the word is the half-bit period
  typedef struct packed {
    row_kind_t           kind;
    logic                act;
    logic [15:0]         word;
    logic                typed;
    ir_mft_pkg::result_t want;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = ir_mft_pkg::ACT_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // Idle rates in percent for the sender and the receiver
  int unsigned send_idle_pct = 9;
  int unsigned stall_pct     = 64;

  // Transmitter state as the predictor sees it
  logic [15:0]           half_ticks = ir_mft_pkg::HALF_BIT_RESET;
  logic [FRAME_BITS-1:0] frame_word = '0;
  logic [3:0]            bit_idx    = '0;
  logic                  in_second  = 1'b0;
  logic [15:0]           tick_cnt   = '0;
  logic                  carrier    = 1'b0;
  logic                  tx_busy    = 1'b0;

  ir_mft_pkg::result_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned result_idx   = 0;

  stim_row_t dir_rows [DIR_ROWS];

  ir_manchester_frame_transmitter_core #(
    .DATA_BITS (DATA_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("mismatch on result %0d, %s: got %0h, expected %0h",
             result_idx, what, got, want);
    mismatch_cnt++;
  endtask

  // Advance the predicted transmitter by one accepted transaction and
  // return the result it should produce.
  function automatic ir_mft_pkg::result_t frame_step(input logic act,
                                                     input logic [15:0] word);
    ir_mft_pkg::result_t r;
    logic                cur;
    r = '0;
    cur = (bit_idx < FRAME_BITS) ? frame_word[FRAME_BITS-1-bit_idx] : 1'b0;
    if (act == ir_mft_pkg::ACT_SEND) begin
      if ((word >> DATA_BITS) != 0) begin
        // Disallowed upper bits: flag it and leave the frame alone
        r.rejected = 1'b1;
      end else begin
        // Restart from the first header bit with the carrier off
        frame_word = {ir_mft_pkg::HEADER_ONES, word[DATA_BITS-1:0]};
        bit_idx    = '0;
        in_second  = 1'b0;
        tick_cnt   = '0;
        carrier    = 1'b0;
        tx_busy    = 1'b1;
      end
    end else if (tx_busy) begin
      tick_cnt = tick_cnt + 16'd1;
      // A zero period compares true on every tick, so it behaves as one
      if (tick_cnt >= half_ticks) begin
        tick_cnt = '0;
        if (bit_idx >= FRAME_BITS) begin
          // Last bit's second half has run out: end the frame
          carrier      = 1'b0;
          tx_busy      = 1'b0;
          bit_idx      = '0;
          in_second    = 1'b0;
          r.frame_done = 1'b1;
        end else if (!in_second) begin
          carrier   = cur;
          in_second = 1'b1;
        end else begin
          carrier   = ~cur;
          in_second = 1'b0;
          bit_idx   = bit_idx + 4'd1;
        end
      end
    end
    r.carrier_on = carrier;
    r.busy_res   = tx_busy;
    return r;
  endfunction

  // Offer one transaction, hold it until accepted, then log what should come back.
  // A typed expectation replaces the predicted one but the predictor still advances.
  task automatic feed_item(input logic act, input logic [15:0] word,
                           input logic typed, input ir_mft_pkg::result_t want);
    ir_mft_pkg::result_t pred;
    int                  gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = frame_step(act, word);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Drop valid, wait for every outstanding result, then let the result stage idle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_half_period(input logic [15:0] value);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    half_ticks = value;
  endtask

  // Score every result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    ir_mft_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", out_tdata, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.carrier_on)
          note_mismatch("carrier_on", 8'(out_tdata[0]), 8'(want.carrier_on));
        if (out_tdata[1] !== want.busy_res)
          note_mismatch("busy_res", 8'(out_tdata[1]), 8'(want.busy_res));
        if (out_tdata[2] !== want.rejected)
          note_mismatch("rejected", 8'(out_tdata[2]), 8'(want.rejected));
        if (out_tlast !== want.frame_done)
          note_mismatch("frame_done", 8'(out_tlast), 8'(want.frame_done));
        if (out_tdata[7:3] !== 5'd0)
          note_mismatch("padding", 8'(out_tdata[7:3]), 8'h00);
      end
      result_idx++;
    end
  end

  initial begin : stimulus
    int          i;
    int          ph;
    int          counted;
    int unsigned eff;
    int unsigned pick;
    logic        act;
    logic [15:0] word;
    logic        was_busy;

    // Directed rows: result fields are {carrier_on, busy_res, frame_done, rejected}
    dir_rows = '{
      // Reset period (889): idle tick, rejects on each upper bit pattern
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h0800, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h8000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'hF800, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
      // Largest legal command starts a frame with the carrier off
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h07FF, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0}},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0}},
      // Send while busy restarts; a rejected send mid-frame keeps it going
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h0000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0}},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h0FFF, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1}},
      // Shortest period: every tick is a half-bit boundary
      '{ROW_CFG,  ir_mft_pkg::ACT_TICK, 16'd1,    1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h0555, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'hFFFF, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_SEND, 16'h02AA, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, ir_mft_pkg::ACT_TICK, 16'h0000, 1'b0, '0}
    };

    // Hold reset, then release it once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with the sender and receiver idling lightly/heavily
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_half_period(dir_rows[i].word);
      else
        feed_item(dir_rows[i].act, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: heavy receiver stalls, then heavy sender gaps, then none
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0:       begin send_idle_pct = 9;  stall_pct = 64; end
        1:       begin send_idle_pct = 64; stall_pct = 9;  end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      set_half_period(HALF_SETTINGS[ph]);
      eff = (half_ticks == 0) ? 1 : ((half_ticks > 100) ? 100 : half_ticks);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        was_busy = tx_busy;
        // Mostly ticks while a frame runs so most frames finish; more sends when idle
        pick = was_busy ? $urandom_range(0, 50 * eff) : $urandom_range(2, 11);
        if (pick == 0 || pick == 2 || pick == 3 || pick == 4) begin
          act = ir_mft_pkg::ACT_SEND;
          case ($urandom_range(0, 7))
            0:       word = 16'h0000;
            1:       word = 16'((1 << DATA_BITS) - 1);
            default: word = 16'($urandom_range(0, (1 << DATA_BITS) - 1));
          endcase
        end else if (pick == 1 || pick == 5) begin
          // Force at least one disallowed upper bit
          act  = ir_mft_pkg::ACT_SEND;
          word = 16'($urandom_range(0, 65535)) | (16'd1 << $urandom_range(DATA_BITS, 15));
        end else begin
          act  = ir_mft_pkg::ACT_TICK;
          word = 16'($urandom_range(0, 65535));
        end
        feed_item(act, word, 1'b0, '0);
        // Ticks while idle are ignored and do not count toward the phase
        if (act == ir_mft_pkg::ACT_SEND || was_busy) counted++;
      end
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
